>>> hw/rtl/sm64_pkg.sv
// ----------------------------------------------------------------------------
// sm64_pkg
// Shared constants, codes and types for the seeded splitmix64 generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sm64_pkg;

  // default seed buffer length and queue depth
  localparam int unsigned SEED_BUFFER_LEN = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QIDX_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  // hash and mixer constants
  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
  localparam logic [63:0] GOLDEN    = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_A     = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_B     = 64'h94D0_49BB_1331_11EB;

  // input mode codes
  localparam logic [2:0] MODE_START    = 3'd0;
  localparam logic [2:0] MODE_BYTE     = 3'd1;
  localparam logic [2:0] MODE_RESEED_S = 3'd2;
  localparam logic [2:0] MODE_RESEED_E = 3'd3;
  localparam logic [2:0] MODE_DRAW_S   = 3'd4;
  localparam logic [2:0] MODE_DRAW_E   = 3'd5;

  // internal operation codes after classification
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_BYTE   = 2'd1;
  localparam logic [1:0] OP_RESEED = 2'd2;
  localparam logic [1:0] OP_DRAW   = 2'd3;

  // one queued operation
  typedef struct packed {
    logic [1:0]  code;
    logic        elite;
    logic [7:0]  seed_byte;
    logic [63:0] salt;
  } op_t;

  // front status
  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } fr_stat_t;

  // back status
  typedef struct packed {
    logic busy;
    logic out_full;
  } core_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/sm64_front.sv
// ----------------------------------------------------------------------------
// sm64_front
// Accepts input words, classifies the mode and queues the operation.
// ----------------------------------------------------------------------------
`default_nettype none

module sm64_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_mode,
  input  wire logic [7:0]        in_seed_byte,
  input  wire logic [63:0]       in_salt,
  output sm64_pkg::op_t          q_op,
  output logic                   q_valid,
  input  wire logic              q_pop,
  output sm64_pkg::fr_stat_t     stat
);
  import sm64_pkg::*;

  op_t               entry_r [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  op_t               cls_op;
  logic              cls_keep;
  logic              push;
  logic              pop;

  // mode decode; unused modes are dropped
  always_comb begin
    cls_op.seed_byte = in_seed_byte;
    cls_op.salt      = in_salt;
    cls_op.code      = OP_START;
    cls_op.elite     = 1'b0;
    cls_keep         = 1'b1;
    unique case (in_mode) inside
      MODE_START: begin
        cls_op.code = OP_START;
      end
      MODE_BYTE: begin
        cls_op.code = OP_BYTE;
      end
      MODE_RESEED_S, MODE_RESEED_E: begin
        cls_op.code  = OP_RESEED;
        cls_op.elite = (in_mode == MODE_RESEED_E);
      end
      MODE_DRAW_S, MODE_DRAW_E: begin
        cls_op.code  = OP_DRAW;
        cls_op.elite = (in_mode == MODE_DRAW_E);
      end
      default: begin
        cls_keep = 1'b0;
      end
    endcase
  end

  // queue control
  assign in_ready   = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready && cls_keep;
  assign q_valid    = (count_r != '0);
  assign pop        = q_pop && q_valid;
  assign q_op       = entry_r[rd_ptr_r];
  assign stat.count = count_r;

  // pointers wrap naturally, depth is a power of two
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QIDX_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QIDX_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls_op;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sm64_core.sv
// ----------------------------------------------------------------------------
// sm64_core
// Executes queued operations on one shared 32x32 multiplier: seed hashing,
// stream reseed and stream draw with the splitmix finalizer.
// ----------------------------------------------------------------------------
`default_nettype none

module sm64_core #(
  parameter int unsigned SEED_LEN = sm64_pkg::SEED_BUFFER_LEN
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  sm64_pkg::op_t         q_op,
  input  wire logic             q_valid,
  output logic                  q_pop,
  output sm64_pkg::core_stat_t  stat,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           out_random_word,
  output logic                  out_from_elite
);
  import sm64_pkg::*;

  localparam int unsigned CNT_W = $clog2(SEED_LEN);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(SEED_LEN - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  // what follows a multiplication
  localparam logic [1:0] PH_FNV  = 2'd0;
  localparam logic [1:0] PH_SALT = 2'd1;
  localparam logic [1:0] PH_MIX1 = 2'd2;
  localparam logic [1:0] PH_MIX2 = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             elite_r, elite_nxt;
  logic             draw_r, draw_nxt;
  logic [63:0]      ma_r, ma_nxt;
  logic [63:0]      mb_r, mb_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [63:0]      hash_r, hash_nxt;
  logic [63:0]      sst_r, sst_nxt;
  logic [63:0]      est_r, est_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ended_r, ended_nxt;
  logic             ov_r, ov_nxt;
  logic [31:0]      ow_r, ow_nxt;
  logic             oe_r, oe_nxt;

  logic [31:0]      mx, my;
  logic [63:0]      prod;
  logic [63:0]      mul_sum;
  logic             out_free;

  assign out_valid       = ov_r;
  assign out_random_word = ow_r;
  assign out_from_elite  = oe_r;
  assign out_free        = !ov_r || out_ready;
  assign stat.busy       = (state_r != ST_IDLE);
  assign stat.out_full   = ov_r;
  assign q_pop           = q_valid && (state_r == ST_IDLE);

  // partial product select: low*low, low*high, high*low
  always_comb begin
    case (step_r)
      2'd0: begin
        mx = ma_r[31:0];
        my = mb_r[31:0];
      end
      2'd1: begin
        mx = ma_r[31:0];
        my = mb_r[63:32];
      end
      default: begin
        mx = ma_r[63:32];
        my = mb_r[31:0];
      end
    endcase
  end

  assign prod    = {32'b0, mx} * {32'b0, my};
  assign mul_sum = (step_r == 2'd0) ? prod : acc_r + {prod[31:0], 32'b0};

  // sequencer
  always_comb begin
    logic [63:0] s_sum;
    logic [63:0] z_sum;
    logic [63:0] fin;
    state_nxt = state_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    elite_nxt = elite_r;
    draw_nxt  = draw_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    acc_nxt   = acc_r;
    hash_nxt  = hash_r;
    sst_nxt   = sst_r;
    est_nxt   = est_r;
    cnt_nxt   = cnt_r;
    ended_nxt = ended_r;
    ov_nxt    = ov_r;
    ow_nxt    = ow_r;
    oe_nxt    = oe_r;
    s_sum     = (q_op.elite ? est_r : sst_r) + GOLDEN;
    z_sum     = hash_r + acc_r;
    fin       = acc_r ^ (acc_r >> 31);

    // result word leaves
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          elite_nxt = q_op.elite;
          step_nxt  = 2'd0;
          unique case (q_op.code)
            OP_START: begin
              hash_nxt  = FNV_BASIS;
              cnt_nxt   = '0;
              ended_nxt = 1'b0;
            end
            OP_BYTE: begin
              if (q_op.seed_byte == 8'd0) begin
                ended_nxt = 1'b1;
              end else if (!ended_r && (cnt_r < CNT_LIMIT)) begin
                ma_nxt    = hash_r ^ {56'b0, q_op.seed_byte};
                mb_nxt    = FNV_PRIME;
                phase_nxt = PH_FNV;
                state_nxt = ST_MUL;
              end
            end
            OP_RESEED: begin
              ma_nxt    = q_op.salt + 64'd1;
              mb_nxt    = GOLDEN;
              phase_nxt = PH_SALT;
              draw_nxt  = 1'b0;
              state_nxt = ST_MUL;
            end
            OP_DRAW: begin
              if (q_op.elite) begin
                est_nxt = s_sum;
              end else begin
                sst_nxt = s_sum;
              end
              ma_nxt    = s_sum ^ (s_sum >> 30);
              mb_nxt    = MIX_A;
              phase_nxt = PH_MIX1;
              draw_nxt  = 1'b1;
              state_nxt = ST_MUL;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL: begin
        acc_nxt  = mul_sum;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        step_nxt = 2'd0;
        unique case (phase_r)
          PH_FNV: begin
            hash_nxt  = acc_r;
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = ST_IDLE;
          end
          PH_SALT: begin
            ma_nxt    = z_sum ^ (z_sum >> 30);
            mb_nxt    = MIX_A;
            phase_nxt = PH_MIX1;
            state_nxt = ST_MUL;
          end
          PH_MIX1: begin
            ma_nxt    = acc_r ^ (acc_r >> 27);
            mb_nxt    = MIX_B;
            phase_nxt = PH_MIX2;
            state_nxt = ST_MUL;
          end
          default: begin
            if (draw_r) begin
              // wait here while the output register is still held
              if (out_free) begin
                ov_nxt    = 1'b1;
                ow_nxt    = fin[63:32];
                oe_nxt    = elite_r;
                state_nxt = ST_IDLE;
              end
            end else begin
              if (elite_r) begin
                est_nxt = fin;
              end else begin
                sst_nxt = fin;
              end
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 2'd0;
      phase_r <= PH_FNV;
      elite_r <= 1'b0;
      draw_r  <= 1'b0;
      hash_r  <= '0;
      sst_r   <= '0;
      est_r   <= '0;
      cnt_r   <= '0;
      ended_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      elite_r <= elite_nxt;
      draw_r  <= draw_nxt;
      hash_r  <= hash_nxt;
      sst_r   <= sst_nxt;
      est_r   <= est_nxt;
      cnt_r   <= cnt_nxt;
      ended_r <= ended_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    ow_r  <= ow_nxt;
    oe_r  <= oe_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/seeded_splitmix64_generator.sv
// ----------------------------------------------------------------------------
// seeded_splitmix64_generator
// Seeded random source: FNV-1a seed hash and two splitmix64 streams.
// ----------------------------------------------------------------------------
// From accept: a draw runs both mixer products, a reseed the salt product and
// then both mixer products, a kept seed byte the FNV product; a start seed only
// loads the basis, and a dropped mode does no back-end work. The back end runs
// one operation at a time, each 64-bit product built from 32x32 partial
// products plus a post step; a draw also holds while out_valid is stalled.
// A two-word queue lets the front accept while the back end works.
// Synchronous active-low reset clears the queue, sequencer, hash, streams.
`default_nettype none

module seeded_splitmix64_generator #(
  parameter int unsigned SEED_BUFFER_LEN = sm64_pkg::SEED_BUFFER_LEN
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_seed_byte,
  input  wire logic [63:0] in_salt,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_random_word,
  output logic             out_from_elite
);
  import sm64_pkg::*;

  op_t        q_op;
  logic       q_valid;
  logic       q_pop;
  fr_stat_t   fr_stat;
  core_stat_t core_stat;

  // accept and classify
  sm64_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_seed_byte (in_seed_byte),
    .in_salt      (in_salt),
    .q_op         (q_op),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .stat         (fr_stat)
  );

  // execute
  sm64_core #(
    .SEED_LEN (SEED_BUFFER_LEN)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_op            (q_op),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .stat            (core_stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .out_from_elite  (out_from_elite)
  );

  // a kept word lands in the queue
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode <= MODE_DRAW_E) |=> fr_stat.count != '0)
    else $error("accepted word missing from queue");

  // no result appears from an idle, empty block
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_stat.count == '0) && !core_stat.busy |=> !$rose(out_valid))
    else $error("result without pending draw");

  // the back end never takes a word while busy
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.busy |-> !q_pop)
    else $error("queue popped while core busy");

  // a held result word stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.out_full && !out_ready |=> out_valid && $stable(out_random_word)
      && $stable(out_from_elite))
    else $error("result word changed while stalled");

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the seeded splitmix64 generator. A scoreboard
// tracks the seed hash and both stream states, predicts every draw and
// compares each emitted word in order. Stimulus is a short directed list,
// then randomized seed sessions with noise, under random handshake stalls.
// ----------------------------------------------------------------------------
import sm64_pkg::*;

class splitmix_scoreboard;
  typedef struct {
    logic [31:0] word;
    logic        elite;
  } draw_t;

  // tracked generator state
  logic [63:0] hash_acc;
  logic [63:0] struct_st;
  logic [63:0] elite_st;
  int unsigned taken;
  bit          ended;

  draw_t       pending_draws[$];
  int unsigned errors;

  function new();
    hash_acc  = '0;
    struct_st = '0;
    elite_st  = '0;
    taken     = 0;
    ended     = 1'b0;
    errors    = 0;
  endfunction

  // splitmix64 output mixer
  function logic [63:0] mix64(input logic [63:0] z);
    logic [63:0] t;
    t = (z ^ (z >> 30)) * MIX_A;
    t = (t ^ (t >> 27)) * MIX_B;
    return t ^ (t >> 31);
  endfunction

  // update state for one accepted input word, queue the draw it causes
  function void note_word(input logic [2:0] mode, input logic [7:0] sbyte,
                          input logic [63:0] salt);
    draw_t d;
    logic [63:0] m;
    case (mode)
      MODE_START: begin
        hash_acc = FNV_BASIS;
        taken    = 0;
        ended    = 1'b0;
      end
      MODE_BYTE: begin
        if (sbyte == 8'h00) begin
          ended = 1'b1;
        end else if (!ended && taken < SEED_BUFFER_LEN - 1) begin
          hash_acc = (hash_acc ^ {56'd0, sbyte}) * FNV_PRIME;
          taken    = (taken + 1) & 8'hFF;
        end
      end
      MODE_RESEED_S: struct_st = mix64(hash_acc + (salt + 64'd1) * GOLDEN);
      MODE_RESEED_E: elite_st  = mix64(hash_acc + (salt + 64'd1) * GOLDEN);
      MODE_DRAW_S: begin
        struct_st = struct_st + GOLDEN;
        m         = mix64(struct_st);
        d.word    = m[63:32];
        d.elite   = 1'b0;
        pending_draws.push_back(d);
      end
      MODE_DRAW_E: begin
        elite_st = elite_st + GOLDEN;
        m        = mix64(elite_st);
        d.word   = m[63:32];
        d.elite  = 1'b1;
        pending_draws.push_back(d);
      end
      default: ;
    endcase
  endfunction

  // compare one emitted word with the oldest predicted draw
  function void check_word(input logic [31:0] word, input logic elite);
    draw_t d;
    if (pending_draws.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected word %h elite %0d", word, elite);
      return;
    end
    d = pending_draws.pop_front();
    if (word !== d.word || elite !== d.elite) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected word %h elite %0d, got word %h elite %0d",
                 d.word, d.elite, word, elite);
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // spare mode codes that the block drops
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int unsigned WORD_TARGET  = 1950;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic [7:0]  in_seed_byte;
  logic [63:0] in_salt;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_random_word;
  logic        out_from_elite;

  splitmix_scoreboard sb;
  int unsigned words_sent;
  bit          tx_calm;
  bit          rx_calm;

  seeded_splitmix64_generator u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_seed_byte    (in_seed_byte),
    .in_salt         (in_salt),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .out_from_elite  (out_from_elite)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // random salt, now and then one of the wrap extremes
  function automatic logic [63:0] rand_salt();
    case ($urandom_range(0, 11))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'hFFFF_FFFF_FFFF_FFFE;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one input word, hold it until taken
  task automatic send_word(input logic [2:0] mode, input logic [7:0] sbyte,
                           input logic [63:0] salt);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_seed_byte <= sbyte;
    in_salt      <= salt;
    do @(posedge clk); while (!in_ready);
    sb.note_word(mode, sbyte, salt);
    if (mode <= MODE_DRAW_E) words_sent++;
    @(negedge clk);
  endtask

  // one seed session: start, string, reseeds, draws; sometimes plain noise
  task automatic seed_session();
    int len;
    int cut;
    tx_calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        send_word(3'($urandom_range(0, 7)), 8'($urandom), rand_salt());
      return;
    end
    if ($urandom_range(0, 11) != 0) send_word(MODE_START, 8'($urandom), rand_salt());
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : -1;
    for (int i = 0; i < len; i++)
      send_word(MODE_BYTE, (i == cut) ? 8'h00 : 8'($urandom_range(1, 255)), rand_salt());
    if ($urandom_range(0, 3) != 0) send_word(MODE_RESEED_S, 8'($urandom), rand_salt());
    if ($urandom_range(0, 3) != 0) send_word(MODE_RESEED_E, 8'($urandom), rand_salt());
    repeat ($urandom_range(1, 8))
      send_word($urandom_range(0, 1) ? MODE_DRAW_E : MODE_DRAW_S, 8'($urandom), rand_salt());
  endtask

  // result side: random stall before each word
  initial begin
    int gap;
    int served;
    out_ready = 1'b0;
    served    = 0;
    rx_calm   = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (served % 16 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      served++;
      @(negedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_random_word, out_from_elite);
  end

  // main sequence
  initial begin
    int waited;
    sb           = new();
    words_sent   = 0;
    tx_calm      = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = MODE_START;
    in_seed_byte = 8'h00;
    in_salt      = 64'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: draws from zero state, bytes without start, reseed wraps
    send_word(MODE_DRAW_S,   8'h00, 64'd0);
    send_word(MODE_DRAW_E,   8'hFF, '1);
    send_word(MODE_BYTE,     8'hFF, 64'd0);
    send_word(MODE_RESEED_S, 8'h00, 64'd0);
    send_word(MODE_DRAW_S,   8'h00, 64'd0);
    send_word(MODE_START,    8'h00, 64'd0);
    send_word(MODE_BYTE,     8'h01, 64'd0);
    send_word(MODE_BYTE,     8'h80, 64'd0);
    send_word(MODE_BYTE,     8'hFF, 64'd0);
    send_word(MODE_RESEED_E, 8'h00, '1);
    send_word(MODE_DRAW_E,   8'h00, 64'd0);
    // end of string, then a byte that must be dropped
    send_word(MODE_BYTE,     8'h00, 64'd0);
    send_word(MODE_BYTE,     8'h5A, 64'd0);
    send_word(MODE_RESEED_S, 8'h00, 64'h8000_0000_0000_0000);
    send_word(MODE_DRAW_S,   8'h00, 64'd0);
    // spare modes carry full payloads and do nothing
    send_word(MODE_SPARE_LO, 8'hFF, '1);
    send_word(MODE_SPARE_HI, 8'hFF, '1);
    send_word(MODE_DRAW_E,   8'h00, 64'd0);
    // restart keeps the streams; reseed from fresh basis
    send_word(MODE_START,    8'hFF, '1);
    send_word(MODE_DRAW_S,   8'h00, 64'd0);
    send_word(MODE_RESEED_E, 8'h00, 64'hFFFF_FFFF_FFFF_FFFE);
    send_word(MODE_DRAW_E,   8'h00, 64'd0);
    send_word(MODE_DRAW_S,   8'h00, 64'd0);

    // random sessions
    while (words_sent < WORD_TARGET) seed_session();
    in_valid <= 1'b0;

    // drain
    waited = 0;
    while (sb.pending_draws.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (sb.pending_draws.size() != 0)
      $display("%0d predicted words never emitted", sb.pending_draws.size());

    if (sb.errors == 0 && sb.pending_draws.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
